[hw/rtl/sfc_pkg.sv]
// Shared types, constants and command microcode of the SPI flash command sequencer.
`default_nettype none
package sfc_pkg;

   localparam logic [24:0] CAPACITY_BYTES = 25'd4194304;
   localparam int unsigned PAGE_BYTES = 256;
   localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Request opcodes.
   localparam logic [2:0] OP_READ = 3'd0;
   localparam logic [2:0] OP_WRITE_START = 3'd1;
   localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
   localparam logic [2:0] OP_SECTOR_ERASE = 3'd3;
   localparam logic [2:0] OP_CHIP_ERASE = 3'd4;
   localparam logic [2:0] OP_BUSY_CHECK = 3'd5;
   localparam logic [2:0] OP_READ_ID = 3'd6;
   localparam logic [2:0] OP_SPI_REPLY = 3'd7;

   // Result kinds.
   localparam logic [2:0] K_CSA = 3'd0;
   localparam logic [2:0] K_CSR = 3'd1;
   localparam logic [2:0] K_SEND = 3'd2;
   localparam logic [2:0] K_DATA = 3'd3;
   localparam logic [2:0] K_DONE = 3'd4;
   localparam logic [2:0] K_ID = 3'd5;

   // Done status codes.
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;
   localparam logic [1:0] ST_SEQUENCE = 2'd3;

   // Flash command bytes.
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_STATUS = 8'h05;
   localparam logic [7:0] CMD_WREN = 8'h06;
   localparam logic [7:0] CMD_ID = 8'h90;
   localparam logic [7:0] CMD_ERASE_4K = 8'h20;
   localparam logic [7:0] CMD_ERASE_32K = 8'h52;
   localparam logic [7:0] CMD_ERASE_64K = 8'hD8;
   localparam logic [7:0] CMD_CHIP = 8'h60;
   localparam logic [7:0] BUSY_MASK = 8'h01;

   // Front phases.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_READ = 3'd1;
   localparam logic [2:0] PH_COLLECT = 3'd2;
   localparam logic [2:0] PH_POLL = 3'd3;
   localparam logic [2:0] PH_CHECK = 3'd4;
   localparam logic [2:0] PH_ID = 3'd5;

   // Command sequences handed from front to back.
   localparam logic [4:0] SQ_DONE = 5'd0;
   localparam logic [4:0] SQ_READ_START = 5'd1;
   localparam logic [4:0] SQ_READ_MORE = 5'd2;
   localparam logic [4:0] SQ_READ_END = 5'd3;
   localparam logic [4:0] SQ_POLL_MORE = 5'd4;
   localparam logic [4:0] SQ_POLL_CLOSE = 5'd5;
   localparam logic [4:0] SQ_POLL_DONE = 5'd6;
   localparam logic [4:0] SQ_CHECK_END = 5'd7;
   localparam logic [4:0] SQ_ID_MORE = 5'd8;
   localparam logic [4:0] SQ_ID_END = 5'd9;
   localparam logic [4:0] SQ_WB_OPEN_END = 5'd10;
   localparam logic [4:0] SQ_WB_OPEN = 5'd11;
   localparam logic [4:0] SQ_WB_END = 5'd12;
   localparam logic [4:0] SQ_WB_MID = 5'd13;
   localparam logic [4:0] SQ_SECTOR = 5'd14;
   localparam logic [4:0] SQ_CHIP = 5'd15;
   localparam logic [4:0] SQ_BUSY = 5'd16;
   localparam logic [4:0] SQ_ID_START = 5'd17;

   // Byte sources of a micro-op.
   localparam logic [2:0] SRC_K = 3'd0;
   localparam logic [2:0] SRC_A2 = 3'd1;
   localparam logic [2:0] SRC_A1 = 3'd2;
   localparam logic [2:0] SRC_A0 = 3'd3;
   localparam logic [2:0] SRC_DB = 3'd4;

   localparam logic [3:0] MAX_STEP = 4'd12;

   typedef struct packed {
      logic [2:0] opcode;
      logic [23:0] address;
      logic [15:0] length;
      logic [1:0] erase_size;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic expect_reply;
      logic [1:0] status;
      logic [15:0] count;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] seq;
      logic [23:0] addr;
      logic [7:0] db;
      logic [1:0] status;
      logic [15:0] count;
   } desc_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] src;
      logic [7:0] cbyte;
      logic rep;
      logic fin;
   } uop_type;

   function automatic uop_type mk(input logic [2:0] kind, input logic [2:0] src,
                                  input logic [7:0] cbyte, input logic rep,
                                  input logic fin);
      uop_type u;
      u.kind = kind;
      u.src = src;
      u.cbyte = cbyte;
      u.rep = rep;
      u.fin = fin;
      return u;
   endfunction

   // Common status-poll opening: deselect, select, status command, dummy byte with reply.
   function automatic uop_type poll_tail(input logic [3:0] s);
      uop_type u;
      case (s)
         4'd0: u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b0);
         4'd1: u = mk(K_CSA, SRC_K, 8'h00, 1'b0, 1'b0);
         4'd2: u = mk(K_SEND, SRC_K, CMD_STATUS, 1'b0, 1'b0);
         default: u = mk(K_SEND, SRC_K, 8'h00, 1'b1, 1'b1);
      endcase
      return u;
   endfunction

   // Write enable, then select and a command byte from the given source.
   function automatic uop_type wren_cmd(input logic [3:0] s, input logic [2:0] src,
                                        input logic [7:0] cb);
      uop_type u;
      case (s)
         4'd0: u = mk(K_CSA, SRC_K, 8'h00, 1'b0, 1'b0);
         4'd1: u = mk(K_SEND, SRC_K, CMD_WREN, 1'b0, 1'b0);
         4'd2: u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b0);
         4'd3: u = mk(K_CSA, SRC_K, 8'h00, 1'b0, 1'b0);
         default: u = mk(K_SEND, src, cb, 1'b0, 1'b0);
      endcase
      return u;
   endfunction

   function automatic uop_type addr_byte(input logic [3:0] s);
      uop_type u;
      case (s)
         4'd0: u = mk(K_SEND, SRC_A2, 8'h00, 1'b0, 1'b0);
         4'd1: u = mk(K_SEND, SRC_A1, 8'h00, 1'b0, 1'b0);
         default: u = mk(K_SEND, SRC_A0, 8'h00, 1'b0, 1'b0);
      endcase
      return u;
   endfunction

   function automatic uop_type flash_uop(input logic [4:0] seq, input logic [3:0] s);
      uop_type u;
      u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
      case (seq)
         SQ_DONE: u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
         SQ_READ_START: begin
            if (s == 4'd0) u = mk(K_CSA, SRC_K, 8'h00, 1'b0, 1'b0);
            else if (s == 4'd1) u = mk(K_SEND, SRC_K, CMD_READ, 1'b0, 1'b0);
            else if (s < 4'd5) u = addr_byte(s - 4'd2);
            else u = mk(K_SEND, SRC_K, 8'h00, 1'b1, 1'b1);
         end
         SQ_READ_MORE, SQ_ID_MORE: begin
            if (s == 4'd0) u = mk((seq == SQ_ID_MORE) ? K_ID : K_DATA, SRC_DB, 8'h00,
                                  1'b0, 1'b0);
            else u = mk(K_SEND, SRC_K, 8'h00, 1'b1, 1'b1);
         end
         SQ_READ_END: begin
            if (s == 4'd0) u = mk(K_DATA, SRC_DB, 8'h00, 1'b0, 1'b0);
            else u = poll_tail(s - 4'd1);
         end
         SQ_POLL_MORE: u = mk(K_SEND, SRC_K, 8'h00, 1'b1, 1'b1);
         SQ_POLL_CLOSE: u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b1);
         SQ_POLL_DONE, SQ_CHECK_END: begin
            if (s == 4'd0) u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b0);
            else u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
         end
         SQ_ID_END: begin
            if (s == 4'd0) u = mk(K_ID, SRC_DB, 8'h00, 1'b0, 1'b0);
            else if (s == 4'd1) u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b0);
            else u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
         end
         SQ_WB_OPEN_END, SQ_WB_OPEN: begin
            if (s < 4'd5) u = wren_cmd(s, SRC_K, CMD_PROGRAM);
            else if (s < 4'd8) u = addr_byte(s - 4'd5);
            else if (s == 4'd8) u = mk(K_SEND, SRC_DB, 8'h00, 1'b0, seq == SQ_WB_OPEN);
            else u = poll_tail(s - 4'd9);
         end
         SQ_WB_END: begin
            if (s == 4'd0) u = mk(K_SEND, SRC_DB, 8'h00, 1'b0, 1'b0);
            else u = poll_tail(s - 4'd1);
         end
         SQ_WB_MID: u = mk(K_SEND, SRC_DB, 8'h00, 1'b0, 1'b1);
         SQ_SECTOR: begin
            if (s < 4'd5) u = wren_cmd(s, SRC_DB, 8'h00);
            else if (s < 4'd8) u = addr_byte(s - 4'd5);
            else if (s == 4'd8) u = mk(K_CSR, SRC_K, 8'h00, 1'b0, 1'b0);
            else u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
         end
         SQ_CHIP: begin
            if (s < 4'd5) u = wren_cmd(s, SRC_K, CMD_CHIP);
            else u = poll_tail(s - 4'd5);
         end
         SQ_BUSY: u = poll_tail(s + 4'd1);
         SQ_ID_START: begin
            if (s == 4'd0) u = mk(K_CSA, SRC_K, 8'h00, 1'b0, 1'b0);
            else if (s == 4'd1) u = mk(K_SEND, SRC_K, CMD_ID, 1'b0, 1'b0);
            else if (s < 4'd5) u = mk(K_SEND, SRC_K, 8'h00, 1'b0, 1'b0);
            else u = mk(K_SEND, SRC_K, 8'h00, 1'b1, 1'b1);
         end
         default: u = mk(K_DONE, SRC_K, 8'h00, 1'b0, 1'b1);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/sfc_front.sv]
// Request front end: checks each request against the flash state and picks a command sequence.
`default_nettype none
module sfc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire sfc_pkg::req_type req,
   output sfc_pkg::desc_type desc,
   output logic enq
);
   import sfc_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [23:0] cur_addr_ff, cur_addr_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] clipped_ff, clipped_in;
   logic page_open_ff, page_open_in;
   logic [2:0] active_ff, active_in;
   logic id_stage_ff, id_stage_in;

   logic out_of_range;
   logic [24:0] room;
   logic [15:0] clip_len;
   logic [15:0] rem_dec;
   logic [23:0] addr_inc;
   logic busy_bit;
   logic wb_end;

   always_comb begin
      out_of_range = {1'b0, req.address} >= CAPACITY_BYTES;
      room = CAPACITY_BYTES - {1'b0, req.address};
      clip_len = ({9'd0, req.length} < room) ? req.length : room[15:0];
      rem_dec = remaining_ff - 16'd1;
      addr_inc = cur_addr_ff + 24'd1;
      busy_bit = (req.data_byte & BUSY_MASK) != 8'd0;
      wb_end = (rem_dec == 16'd0) || (addr_inc[PAGE_BITS-1:0] == '0);

      phase_in = phase_ff;
      cur_addr_in = cur_addr_ff;
      remaining_in = remaining_ff;
      clipped_in = clipped_ff;
      page_open_in = page_open_ff;
      active_in = active_ff;
      id_stage_in = id_stage_ff;
      enq = 1'b1;
      desc.seq = SQ_DONE;
      desc.addr = req.address;
      desc.db = req.data_byte;
      desc.status = ST_OK;
      desc.count = 16'd0;

      if (req.opcode == OP_SPI_REPLY) begin
         case (phase_ff)
            PH_READ: begin
               remaining_in = rem_dec;
               if (rem_dec != 16'd0) begin
                  desc.seq = SQ_READ_MORE;
               end else begin
                  desc.seq = SQ_READ_END;
                  active_in = OP_READ;
                  phase_in = PH_POLL;
               end
            end
            PH_POLL: begin
               if (busy_bit) begin
                  desc.seq = SQ_POLL_MORE;
               end else if (active_ff == OP_WRITE_START && remaining_ff != 16'd0) begin
                  desc.seq = SQ_POLL_CLOSE;
                  phase_in = PH_COLLECT;
               end else begin
                  desc.seq = SQ_POLL_DONE;
                  desc.count = (active_ff == OP_CHIP_ERASE) ? 16'd0 : clipped_ff;
                  phase_in = PH_IDLE;
               end
            end
            PH_CHECK: begin
               desc.seq = SQ_CHECK_END;
               desc.status = busy_bit ? ST_BUSY : ST_OK;
               phase_in = PH_IDLE;
            end
            PH_ID: begin
               if (!id_stage_ff) begin
                  desc.seq = SQ_ID_MORE;
                  id_stage_in = 1'b1;
               end else begin
                  desc.seq = SQ_ID_END;
                  id_stage_in = 1'b0;
                  phase_in = PH_IDLE;
               end
            end
            default: enq = 1'b0;
         endcase
      end else if (req.opcode == OP_WRITE_BYTE && phase_ff == PH_COLLECT) begin
         desc.addr = cur_addr_ff;
         if (!page_open_ff) desc.seq = wb_end ? SQ_WB_OPEN_END : SQ_WB_OPEN;
         else desc.seq = wb_end ? SQ_WB_END : SQ_WB_MID;
         cur_addr_in = addr_inc;
         remaining_in = rem_dec;
         page_open_in = !wb_end;
         if (wb_end) begin
            active_in = OP_WRITE_START;
            phase_in = PH_POLL;
         end
      end else if (phase_ff != PH_IDLE || req.opcode == OP_WRITE_BYTE) begin
         desc.status = ST_SEQUENCE;
      end else begin
         case (req.opcode)
            OP_READ, OP_WRITE_START: begin
               if (out_of_range) begin
                  desc.status = ST_RANGE;
               end else if (clip_len != 16'd0) begin
                  clipped_in = clip_len;
                  remaining_in = clip_len;
                  cur_addr_in = req.address;
                  active_in = req.opcode;
                  if (req.opcode == OP_READ) begin
                     desc.seq = SQ_READ_START;
                     phase_in = PH_READ;
                  end else begin
                     enq = 1'b0;
                     page_open_in = 1'b0;
                     phase_in = PH_COLLECT;
                  end
               end
            end
            OP_SECTOR_ERASE: begin
               if (out_of_range) begin
                  desc.status = ST_RANGE;
               end else begin
                  desc.seq = SQ_SECTOR;
                  case (req.erase_size)
                     2'd1: desc.db = CMD_ERASE_32K;
                     2'd2: desc.db = CMD_ERASE_64K;
                     default: desc.db = CMD_ERASE_4K;
                  endcase
               end
            end
            OP_CHIP_ERASE: begin
               desc.seq = SQ_CHIP;
               active_in = OP_CHIP_ERASE;
               phase_in = PH_POLL;
            end
            OP_BUSY_CHECK: begin
               desc.seq = SQ_BUSY;
               active_in = OP_BUSY_CHECK;
               phase_in = PH_CHECK;
            end
            default: begin
               desc.seq = SQ_ID_START;
               id_stage_in = 1'b0;
               active_in = OP_READ_ID;
               phase_in = PH_ID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_addr_ff <= '0;
         remaining_ff <= '0;
         clipped_ff <= '0;
         page_open_ff <= 1'b0;
         active_ff <= '0;
         id_stage_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cur_addr_ff <= cur_addr_in;
         remaining_ff <= remaining_in;
         clipped_ff <= clipped_in;
         page_open_ff <= page_open_in;
         active_ff <= active_in;
         id_stage_ff <= id_stage_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/sfc_queue.sv]
// Small command queue between the front end and the byte sequencer.
`default_nettype none
module sfc_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire sfc_pkg::desc_type push_data,
   output logic full,
   input wire logic pop,
   output logic nonempty,
   output sfc_pkg::desc_type head
);
   import sfc_pkg::*;

   desc_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0] fill_ff;

   assign full = fill_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
   assign nonempty = fill_ff != '0;
   assign head = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) fill_ff <= fill_ff + 1'b1;
         else if (pop && !push) fill_ff <= fill_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("queue read while empty");
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("queue fill count lost a push");

endmodule
`default_nettype wire

[hw/rtl/sfc_back.sv]
// Byte sequencer: expands each queued command into chip-select, byte and done transactions.
`default_nettype none
module sfc_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic nonempty,
   input wire sfc_pkg::desc_type head,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output sfc_pkg::rsp_type rsp_data
);
   import sfc_pkg::*;

   logic [3:0] step_ff;
   logic valid_ff;
   rsp_type data_ff, data_in;
   uop_type u;
   logic load;

   always_comb begin
      u = flash_uop(head.seq, step_ff);
      load = nonempty && (!valid_ff || rsp_ready);
      pop = load && u.fin;
      data_in.kind = u.kind;
      case (u.src)
         SRC_A2: data_in.out_byte = head.addr[23:16];
         SRC_A1: data_in.out_byte = head.addr[15:8];
         SRC_A0: data_in.out_byte = head.addr[7:0];
         SRC_DB: data_in.out_byte = head.db;
         default: data_in.out_byte = u.cbyte;
      endcase
      data_in.expect_reply = u.rep;
      data_in.status = (u.kind == K_DONE) ? head.status : ST_OK;
      data_in.count = (u.kind == K_DONE) ? head.count : 16'd0;
      data_in.last = u.fin;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         step_ff <= u.fin ? 4'd0 : step_ff + 4'd1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= MAX_STEP)
      else $error("sequence step beyond longest command");
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !nonempty |-> step_ff == 4'd0)
      else $error("step left nonzero with no command queued");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_data.last)
      else $error("command retired without a last transaction");

endmodule
`default_nettype wire

[hw/rtl/spi_flash_command_sequencer.sv]
// Top level of the SPI flash command sequencer: front end, command queue and byte sequencer.
// With the command queue empty, an accepted request that is queued is written into the queue,
// and the byte sequencer then registers its first result into rsp_data and raises rsp_valid.
// Throughput: one result transaction per cycle from the byte sequencer while rsp_ready is high;
// a request expands into up to thirteen results and holds the sequencer until its last is taken.
// Requests are taken every cycle while the four-entry command queue has room.
// Synchronous active-high reset returns the front end to idle and empties the queue.
`default_nettype none
module spi_flash_command_sequencer (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire sfc_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output sfc_pkg::rsp_type rsp_data
);
   import sfc_pkg::*;

   desc_type desc, head;
   logic enq, full, nonempty, pop, accept;

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   sfc_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .desc(desc),
      .enq(enq)
   );

   sfc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept && enq),
      .push_data(desc),
      .full(full),
      .pop(pop),
      .nonempty(nonempty),
      .head(head)
   );

   sfc_back u_back (
      .clock(clock),
      .reset(reset),
      .nonempty(nonempty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire
